// ----- rtl/htdd_pkg.sv -----
// Shared types and constants for the HTTP transfer direction detector.
package htdd_pkg;

    localparam int DATA_W = 8;
    localparam int DIR_W  = 2;

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE     = 2'd0,
        DIR_DOWNLOAD = 2'd1,
        DIR_UPLOAD   = 2'd2
    } dir_t;

    localparam int LEN_GET   = 3;
    localparam int LEN_POST  = 4;
    localparam int LEN_DISP  = 19;
    localparam int LEN_MULTI = 23;

    // First pattern character sits in the most significant byte.
    localparam logic [8*LEN_GET-1:0]   PAT_GET   = "GET";
    localparam logic [8*LEN_POST-1:0]  PAT_POST  = "POST";
    localparam logic [8*LEN_DISP-1:0]  PAT_DISP  = "Content-Disposition";
    localparam logic [8*LEN_MULTI-1:0] PAT_MULTI = "Content-Type: multipart";

    typedef struct packed {
        logic en;
        logic clr;
    } match_ctrl_t;

endpackage

// ----- rtl/htdd_matcher.sv -----
// Literal string matcher advancing one byte per enabled cycle.
module htdd_matcher #(
    parameter int LEN = htdd_pkg::LEN_GET,
    parameter logic [8*LEN-1:0] PATTERN = htdd_pkg::PAT_GET
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  htdd_pkg::match_ctrl_t       ctrl,
    input  logic [htdd_pkg::DATA_W-1:0] data,
    output logic                        hit
);

    localparam int PW = $clog2(LEN);
    localparam logic [7:0] FIRST_BYTE = PATTERN[8*LEN-1 -: 8];

    logic [PW-1:0] progress_reg, progress_next;
    logic [7:0]    want_byte;

    assign want_byte = PATTERN[8*(LEN-1-int'(progress_reg)) +: 8];

    // No pattern repeats its first byte, so a mismatch restarts at zero or one.
    always_comb begin
        hit           = 1'b0;
        progress_next = progress_reg;
        if (ctrl.en) begin
            if (data == want_byte) begin
                if (progress_reg == PW'(LEN-1)) begin
                    hit           = 1'b1;
                    progress_next = '0;
                end else begin
                    progress_next = progress_reg + PW'(1);
                end
            end else begin
                progress_next = (data == FIRST_BYTE) ? PW'(1) : '0;
            end
        end
        if (ctrl.clr) begin
            progress_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            progress_reg <= '0;
        end else begin
            progress_reg <= progress_next;
        end
    end

endmodule

// ----- rtl/http_transfer_direction_detector.sv -----
// Top level of the HTTP transfer direction detector.
//
// The input stream carries one message byte per word on s_tdata, with s_tlast on
// the final byte. Four literal matchers look for GET, Content-Disposition after
// the GET, POST, and Content-Type: multipart after the POST. After the final byte
// one result word leaves on the m_ side: 0 none, 1 download, 2 upload.
// Words without s_tlast produce no result.
//
// A byte is captured in an input register and evaluated by the matchers as it
// leaves, and the result is held in an output register. One byte is taken every
// cycle unless a final byte waits; the rate is set by the single matcher pass
// between the two registers. When the receiver stalls, bytes without s_tlast
// keep flowing; a final byte waits in the input register until the output
// register is free, and s_tready falls while it waits. Reset clears all match
// progress and both valid flags.
module http_transfer_direction_detector (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] direction, [7:2] zero
);

    logic                        in_valid_reg;
    logic [htdd_pkg::DATA_W-1:0] in_byte_reg;
    logic                        in_last_reg;
    logic                        m_tvalid_reg;
    logic [7:0]                  m_tdata_reg;

    logic get_seen_reg, get_seen_next;
    logic disp_seen_reg, disp_seen_next;
    logic post_seen_reg, post_seen_next;
    logic multi_seen_reg, multi_seen_next;

    logic out_free, fire, fin;
    logic get_hit, disp_hit, post_hit, multi_hit;
    htdd_pkg::match_ctrl_t get_ctrl, disp_ctrl, post_ctrl, multi_ctrl;
    htdd_pkg::dir_t direction;

    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = in_valid_reg && (!in_last_reg || out_free);
    assign fin      = fire && in_last_reg;
    assign s_tready = !in_valid_reg || fire;

    assign get_ctrl   = '{en: fire && !get_seen_reg, clr: fin};
    assign disp_ctrl  = '{en: fire && get_seen_reg && !disp_seen_reg, clr: fin};
    assign post_ctrl  = '{en: fire && !post_seen_reg, clr: fin || get_hit};
    assign multi_ctrl = '{en: fire && post_seen_reg && !multi_seen_reg,
                          clr: fin || get_hit};

    htdd_matcher #(.LEN(htdd_pkg::LEN_GET), .PATTERN(htdd_pkg::PAT_GET)) u_get (
        .aclk(aclk), .aresetn(aresetn), .ctrl(get_ctrl), .data(in_byte_reg), .hit(get_hit)
    );
    htdd_matcher #(.LEN(htdd_pkg::LEN_DISP), .PATTERN(htdd_pkg::PAT_DISP)) u_disp (
        .aclk(aclk), .aresetn(aresetn), .ctrl(disp_ctrl), .data(in_byte_reg), .hit(disp_hit)
    );
    htdd_matcher #(.LEN(htdd_pkg::LEN_POST), .PATTERN(htdd_pkg::PAT_POST)) u_post (
        .aclk(aclk), .aresetn(aresetn), .ctrl(post_ctrl), .data(in_byte_reg), .hit(post_hit)
    );
    htdd_matcher #(.LEN(htdd_pkg::LEN_MULTI), .PATTERN(htdd_pkg::PAT_MULTI)) u_multi (
        .aclk(aclk), .aresetn(aresetn), .ctrl(multi_ctrl), .data(in_byte_reg),
        .hit(multi_hit)
    );

    // The first GET discards whatever the POST track has found so far.
    always_comb begin
        get_seen_next   = get_seen_reg;
        disp_seen_next  = disp_seen_reg;
        post_seen_next  = post_seen_reg;
        multi_seen_next = multi_seen_reg;
        if (fire) begin
            if (fin) begin
                get_seen_next   = 1'b0;
                disp_seen_next  = 1'b0;
                post_seen_next  = 1'b0;
                multi_seen_next = 1'b0;
            end else begin
                if (get_hit) begin
                    get_seen_next   = 1'b1;
                    post_seen_next  = 1'b0;
                    multi_seen_next = 1'b0;
                end else begin
                    if (post_hit) begin
                        post_seen_next = 1'b1;
                    end
                    if (multi_hit) begin
                        multi_seen_next = 1'b1;
                    end
                end
                if (disp_hit) begin
                    disp_seen_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (disp_seen_reg || disp_hit) begin
            direction = htdd_pkg::DIR_DOWNLOAD;
        end else if ((multi_seen_reg || multi_hit) && !get_hit) begin
            direction = htdd_pkg::DIR_UPLOAD;
        end else begin
            direction = htdd_pkg::DIR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            get_seen_reg   <= 1'b0;
            disp_seen_reg  <= 1'b0;
            post_seen_reg  <= 1'b0;
            multi_seen_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (fin) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            get_seen_reg   <= get_seen_next;
            disp_seen_reg  <= disp_seen_next;
            post_seen_reg  <= post_seen_next;
            multi_seen_reg <= multi_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fin) begin
            m_tdata_reg <= {6'd0, direction};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/htdd_checker.sv -----
// Port-level assertions for the HTTP transfer direction detector, bound to the top.
module htdd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A reset cycle always leaves the result channel empty.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Only the three defined direction codes are ever shown.
    a_dir_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("undefined direction code");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'd0))
        else $error("padding bits of result not zero");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The input side never blocks a word while the result channel stays empty,
    // with or without tlast; a held result stops only a final byte.
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && $past(!m_tvalid) && $past(aresetn) |-> s_tready)
        else $error("input blocked with output empty");

endmodule

bind http_transfer_direction_detector htdd_checker u_htdd_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

// ----- sim/tb_http_transfer_direction_detector.sv -----
// Self-checking testbench for the HTTP transfer direction detector stream block.
`timescale 1ns / 1ps

module tb_http_transfer_direction_detector;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_STALL   = 250;
    localparam int MAX_REPORTS  = 30;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       hold;   // wait for all outstanding results before offering
    } msg_byte_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [1:0] direction, [7:2] zero

    http_transfer_direction_detector uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    msg_byte_t       pending_bytes[$];
    htdd_pkg::dir_t  expected_dirs[$];
    logic [7:0]      msg[$];

    int cycle_count = 0;
    int bytes_sent = 0;
    int messages_built = 0;
    int results_seen = 0;
    int fail_count = 0;
    int dir_counts[3] = '{0, 0, 0};
    int stall_left = 0;
    bit stall_done = 0;
    bit quiet;

    // Predictor state, one copy per matcher.
    logic [1:0] get_cnt;
    logic       got_get;
    logic [4:0] disp_cnt;
    logic       got_disp;
    logic [2:0] post_cnt;
    logic       got_post;
    logic [4:0] multi_cnt;
    logic       got_multi;

    // No pattern repeats its first character, so a miss restarts at 0 or 1.
    function automatic bit match_step(input logic [183:0] pat, input int len,
                                      inout int prog, input logic [7:0] c);
        int p;
        p = (prog >= len) ? 0 : prog;
        if (c == pat[8*(len-1-p) +: 8]) begin
            p++;
            if (p == len) begin
                prog = 0;
                return 1'b1;
            end
            prog = p;
            return 1'b0;
        end
        prog = (c == pat[8*(len-1) +: 8]) ? 1 : 0;
        return 1'b0;
    endfunction

    task automatic clear_tracks(input bit all_tracks);
        post_cnt  = '0;
        got_post  = 1'b0;
        multi_cnt = '0;
        got_multi = 1'b0;
        if (all_tracks) begin
            get_cnt  = '0;
            got_get  = 1'b0;
            disp_cnt = '0;
            got_disp = 1'b0;
        end
    endtask

    task automatic predict_direction(input msg_byte_t b);
        int t;
        bit get_before;
        bit post_before;
        bit get_hit;
        get_before  = got_get;
        post_before = got_post;
        get_hit     = 1'b0;
        if (get_before) begin
            if (!got_disp) begin
                t = disp_cnt;
                if (match_step(htdd_pkg::PAT_DISP, htdd_pkg::LEN_DISP, t, b.data))
                    got_disp = 1'b1;
                disp_cnt = t[4:0];
            end
        end else begin
            t = get_cnt;
            if (match_step(htdd_pkg::PAT_GET, htdd_pkg::LEN_GET, t, b.data)) begin
                got_get = 1'b1;
                get_hit = 1'b1;
            end
            get_cnt = t[1:0];
        end
        if (post_before) begin
            if (!got_multi) begin
                t = multi_cnt;
                if (match_step(htdd_pkg::PAT_MULTI, htdd_pkg::LEN_MULTI, t, b.data))
                    got_multi = 1'b1;
                multi_cnt = t[4:0];
            end
        end else begin
            t = post_cnt;
            if (match_step(htdd_pkg::PAT_POST, htdd_pkg::LEN_POST, t, b.data))
                got_post = 1'b1;
            post_cnt = t[2:0];
        end
        // A GET discards whatever the POST track had found so far.
        if (get_hit) clear_tracks(1'b0);
        if (b.last) begin
            expected_dirs.push_back(got_disp ? htdd_pkg::DIR_DOWNLOAD :
                                    got_multi ? htdd_pkg::DIR_UPLOAD :
                                    htdd_pkg::DIR_NONE);
            clear_tracks(1'b1);
        end
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
    endtask

    // Leading part of a pattern that stops short of completing it.
    task automatic add_cut(input string s);
        add_text(s.substr(0, $urandom_range(0, s.len() - 2)));
    endtask

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++) msg.push_back(8'($urandom_range(255)));
    endtask

    task automatic finish_message(input bit hold);
        msg_byte_t b;
        for (int i = 0; i < msg.size(); i++) begin
            b.data = msg[i];
            b.last = (i == msg.size() - 1);
            b.hold = hold && (i == 0);
            pending_bytes.push_back(b);
        end
        msg.delete();
        messages_built++;
    endtask

    // Word driver: the head of the queue is offered until it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_direction(pending_bytes[0]);
                void'(pending_bytes.pop_front());
                bytes_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // Word stays on the bus until accepted.
            end else if (pending_bytes.size() != 0 &&
                         !(pending_bytes[0].hold && expected_dirs.size() != 0) &&
                         (quiet || $urandom_range(99) >= 7)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_bytes[0].data;
                s_tlast  <= pending_bytes[0].last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver back-pressure.
    always @(posedge aclk) begin
        htdd_pkg::dir_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_dirs.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with none expected, got tdata=%h",
                                 $time, m_tdata);
                end else begin
                    want = expected_dirs.pop_front();
                    dir_counts[want]++;
                    if (m_tdata[1:0] !== want) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: direction mismatch, expected %0d, got %0d",
                                     $time, want, m_tdata[1:0]);
                    end
                    if (m_tdata[7:2] !== 6'd0) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: padding mismatch, expected 0, got %h",
                                     $time, m_tdata[7:2]);
                    end
                end
            end
            // One long hold-off so the final byte of a message backs up the input.
            if (stall_left > 0) begin
                stall_left--;
            end else if (!stall_done && results_seen == 10) begin
                stall_left = LONG_STALL;
                stall_done = 1'b1;
            end
            m_tready <= (stall_left == 0) && (quiet || $urandom_range(99) >= 7);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_dirs.size());
            $display("http_transfer_direction_detector test failed");
            $finish;
        end
    end

    // Both sides run without idling through this stretch.
    assign quiet = (cycle_count >= 300) && (cycle_count < 700);

    initial begin
        bit hold_mid;
        clear_tracks(1'b1);

        // Directed messages: extremes of the byte and restart on a repeated
        // first character.
        msg.push_back(8'h00);
        finish_message(1'b0);
        add_text("GGET");
        msg.push_back(8'hFF);
        finish_message(1'b0);
        add_text("PPOST");
        finish_message(1'b0);
        add_text("GEGET");
        finish_message(1'b0);
        msg.push_back(8'h80);
        add_text("POSGET");
        finish_message(1'b0);

        hold_mid = 1'b0;
        while (pending_bytes.size() < 500) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    add_noise($urandom_range(0, 3));
                    add_text("GET");
                    add_noise($urandom_range(0, 4));
                    if ($urandom_range(3) != 0) add_text("Content-Disposition");
                    else add_cut("Content-Disposition");
                    add_noise($urandom_range(0, 2));
                end
                2, 3: begin
                    add_noise($urandom_range(0, 3));
                    add_text("POST");
                    add_noise($urandom_range(0, 4));
                    if ($urandom_range(3) != 0) add_text("Content-Type: multipart");
                    else add_cut("Content-Type: multipart");
                    add_noise($urandom_range(0, 2));
                end
                4: begin
                    // POST before GET is discarded; after GET it still counts.
                    if ($urandom_range(1)) begin
                        add_text("GET ");
                        add_text("POST ");
                    end else begin
                        add_text("POST ");
                        add_text("GET ");
                    end
                    add_text("Content-Type: multipart");
                    if ($urandom_range(1)) add_text("Content-Disposition");
                end
                5: begin
                    add_text("PPOST");
                    add_text("CContent-Content-Type: multipart");
                    if ($urandom_range(1)) begin
                        add_text("GGET");
                        add_text("Content-Content-Disposition");
                    end
                end
                6, 7: begin
                    add_noise($urandom_range(1, 4));
                end
                default: begin
                    repeat ($urandom_range(2, 5)) begin
                        case ($urandom_range(0, 5))
                            0: add_text("GET");
                            1: add_text("POST");
                            2: add_text("Content-Disposition");
                            3: add_text("Content-Type: multipart");
                            4: add_cut("Content-Type: multipart");
                            default: add_noise($urandom_range(1, 3));
                        endcase
                    end
                end
            endcase
            // The sender pauses for a full drain after the directed messages
            // and once more halfway through.
            if (messages_built == 5) begin
                finish_message(1'b1);
            end else if (!hold_mid && pending_bytes.size() >= 260) begin
                hold_mid = 1'b1;
                finish_message(1'b1);
            end else begin
                finish_message(1'b0);
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_dirs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Streamed %0d bytes in %0d messages; %0d results checked",
                 bytes_sent, messages_built, results_seen);
        $display("Directions seen: %0d none, %0d download, %0d upload; %0d errors",
                 dir_counts[htdd_pkg::DIR_NONE], dir_counts[htdd_pkg::DIR_DOWNLOAD],
                 dir_counts[htdd_pkg::DIR_UPLOAD], fail_count);
        if (fail_count == 0) begin
            $display("http_transfer_direction_detector test passed");
        end else begin
            $display("http_transfer_direction_detector test failed");
        end
        $finish;
    end

endmodule
